// ===== sv/swls_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swls_pkg: shared constants for the sliding window lane search
// Frame geometry, derived widths, register indexes and helper functions.
// ----------------------------------------------------------------------------
package swls_pkg;

    // frame geometry
    localparam int IMAGE_WIDTH  = 640;
    localparam int IMAGE_HEIGHT = 480;
    localparam int BANDS        = 8;
    localparam int WINDOWS      = 16;

    localparam int BAND_ROWS  = IMAGE_HEIGHT / BANDS;
    localparam int WIN_COLS   = IMAGE_WIDTH / WINDOWS;
    localparam int TOP_SKIP   = IMAGE_HEIGHT - BANDS * BAND_ROWS;
    localparam int COUNT_COLS = WINDOWS * WIN_COLS;
    localparam int DEPTH      = BANDS * WINDOWS;

    // derived widths
    localparam int COL_W  = (IMAGE_WIDTH > 1) ? $clog2(IMAGE_WIDTH) : 1;
    localparam int ROW_W  = (IMAGE_HEIGHT > 1) ? $clog2(IMAGE_HEIGHT) : 1;
    localparam int BAND_W = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int WIN_W  = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
    localparam int BROW_W = (BAND_ROWS > 1) ? $clog2(BAND_ROWS) : 1;
    localparam int WCOL_W = (WIN_COLS > 1) ? $clog2(WIN_COLS) : 1;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CTR_W  = 12;

    // payload widths
    localparam int PIX_W    = 8;
    localparam int CNT_W    = 12;
    localparam int RAD_W    = 4;
    localparam int OBAND_W  = 3;
    localparam int OWIN_W   = 4;
    localparam int CX_W     = 10;
    localparam int CY_W     = 9;
    localparam int POINTS_W = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [PIX_W-1:0] PIX_WHITE = '1;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LIMIT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_RADIUS = 1'b1;
    localparam logic [CNT_W-1:0] COUNT_LIMIT_RST   = 12'd4095;
    localparam logic [RAD_W-1:0] SEARCH_RADIUS_RST = 4'd2;

    // halve with round to nearest, ties to even
    function automatic logic [CTR_W-1:0] half_even(input logic [CTR_W-1:0] s);
        logic [CTR_W-1:0] q;
        q = s >> 1;
        if (s[0] && q[0]) begin
            q = q + CTR_W'(1);
        end
        return q;
    endfunction

endpackage
`default_nettype wire

// ===== sv/swls_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swls_ram: generic single write port RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module swls_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // storage with registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== sv/sliding_window_lane_search_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_lane_search_top: lane search over a camera frame
// Counts white pixels per window and walks the bands after each frame.
// ----------------------------------------------------------------------------
// Usage
//   Pixels enter on the s_ channel in raster order, top row first, one per
//   cycle while s_ready is high. The pixel flagged s_end_of_frame starts the
//   band walk: s_ready drops and one request per band (band 0 first) leaves
//   on the m_ channel, the last one with m_last and m_enough_points.
//   Throughput: one pixel per cycle while s_ready is high. White counts live
//   in a single RAM with a read-modify-write pipeline; back-to-back hits on
//   one window are forwarded. The walk reads that RAM through its one read
//   port, one window a cycle; each band goes through setup, a scan of its
//   search range, a final compare and emit, and s_ready returns once the
//   last band's request has been emitted.
//   A stalled m_ready holds the request and pauses the walk. Window counts
//   are cleared at once through per-entry valid bits, at reset and at the
//   end of every walk. cfg_wr_en writes count_limit (index 0) or
//   search_radius (index 1); write only while idle.
// ----------------------------------------------------------------------------
module sliding_window_lane_search_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [swls_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [swls_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [swls_pkg::PIX_W-1:0]      s_blue,
    input  wire logic [swls_pkg::PIX_W-1:0]      s_green,
    input  wire logic [swls_pkg::PIX_W-1:0]      s_red,
    input  wire logic                            s_end_of_frame,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [swls_pkg::OBAND_W-1:0]         m_band,
    output logic                                 m_found,
    output logic [swls_pkg::OWIN_W-1:0]          m_window,
    output logic [swls_pkg::CX_W-1:0]            m_center_x,
    output logic [swls_pkg::CY_W-1:0]            m_center_y,
    output logic                                 m_enough_points,
    output logic                                 m_last
);
    import swls_pkg::*;

    typedef enum logic [2:0] {
        ST_PIX,
        ST_DRAIN,
        ST_SETUP,
        ST_SCAN,
        ST_LAST,
        ST_EMIT
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [CNT_W-1:0] count_limit_reg;
    logic [RAD_W-1:0] search_radius_reg;

    // pixel position
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [WCOL_W-1:0] wcol_reg;
    logic [WIN_W-1:0]  win_reg;
    logic [BROW_W-1:0] brow_reg;
    logic [BAND_W-1:0] band_reg;

    // count pipeline
    logic              s1_vld_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              rv_bit_reg;
    logic              lw_en_reg;
    logic [ADDR_W-1:0] lw_addr_reg;
    logic [CNT_W-1:0]  lw_data_reg;
    logic [DEPTH-1:0]  valid_reg;

    // walk state
    logic [BAND_W-1:0]   wband_reg;
    logic [WIN_W-1:0]    idx_reg;
    logic [WIN_W-1:0]    hi_reg;
    logic                rd_pend_reg;
    logic [WIN_W-1:0]    rd_idx_reg;
    logic [CNT_W-1:0]    best_cnt_reg;
    logic [WIN_W-1:0]    best_idx_reg;
    logic [WIN_W-1:0]    tracked_reg;
    logic                tracking_reg;
    logic [POINTS_W-1:0] points_reg;

    logic              pix_accept;
    logic              white;
    logic              count_ok;
    logic [ADDR_W-1:0] pix_addr;
    logic [ADDR_W-1:0] walk_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [CNT_W-1:0]  rd_data;
    logic [CNT_W-1:0]  cur_cnt;
    logic [CNT_W-1:0]  wr_data;
    logic [CNT_W-1:0]  walk_cnt;
    logic              out_free;
    logic              emit_go;
    logic              walk_done;
    logic [WIN_W-1:0]  lo_win;
    logic [WIN_W-1:0]  hi_win;
    logic [WIN_W:0]    hi_sum;
    logic              found;
    logic [POINTS_W-1:0] points_next;
    logic [CTR_W-1:0]  sx;
    logic [CTR_W-1:0]  sy;

    // pixel classification and count address
    assign s_ready    = (state_reg == ST_PIX);
    assign pix_accept = s_valid && s_ready;
    assign white      = (s_blue == PIX_WHITE) && (s_green == PIX_WHITE) && (s_red == PIX_WHITE);
    assign count_ok   = white && (row_reg >= ROW_W'(TOP_SKIP))
                        && (COL_W'(col_reg) < COL_W'(COUNT_COLS - 1) + COL_W'(1)
                            || COUNT_COLS == IMAGE_WIDTH);
    assign pix_addr   = ADDR_W'(int'(band_reg) * WINDOWS + int'(win_reg));
    assign walk_addr  = ADDR_W'(int'(wband_reg) * WINDOWS + int'(idx_reg));
    assign rd_addr    = (state_reg == ST_SCAN) ? walk_addr : pix_addr;

    // read-modify-write with forwarding of the previous write
    assign cur_cnt = (lw_en_reg && (lw_addr_reg == s1_addr_reg)) ? lw_data_reg
                   : (rv_bit_reg ? rd_data : '0);
    assign wr_data = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + CNT_W'(1);
    assign walk_cnt = rv_bit_reg ? rd_data : '0;

    swls_ram #(
        .DATA_W (CNT_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_count_ram (
        .aclk    (aclk),
        .wr_en   (s1_vld_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // search range for the current band
    assign hi_sum = {1'b0, tracked_reg} + {1'b0, search_radius_reg};
    always_comb begin
        if (!tracking_reg) begin
            lo_win = '0;
            hi_win = WIN_W'(WINDOWS - 1);
        end else begin
            lo_win = (tracked_reg >= search_radius_reg) ? tracked_reg - search_radius_reg : '0;
            hi_win = (hi_sum > (WIN_W + 1)'(WINDOWS - 1)) ? WIN_W'(WINDOWS - 1)
                                                          : hi_sum[WIN_W-1:0];
        end
    end

    // band result
    assign out_free    = !m_valid || m_ready;
    assign emit_go     = (state_reg == ST_EMIT) && out_free;
    assign walk_done   = emit_go && (wband_reg == BAND_W'(BANDS - 1));
    assign found       = (best_cnt_reg != '0);
    assign points_next = found ? points_reg + POINTS_W'(1) : points_reg;
    assign sx = half_even(CTR_W'((2 * int'(best_idx_reg) + 1) * WIN_COLS));
    assign sy = half_even(CTR_W'(2 * (IMAGE_HEIGHT - (int'(wband_reg) + 1) * BAND_ROWS)
                                 + BAND_ROWS));

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_limit_reg   <= COUNT_LIMIT_RST;
            search_radius_reg <= SEARCH_RADIUS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_COUNT_LIMIT:   count_limit_reg   <= cfg_wdata[CNT_W-1:0];
                CFG_SEARCH_RADIUS: search_radius_reg <= cfg_wdata[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // pixel position tracking
    always_ff @(posedge aclk) begin
        if (!aresetn || (pix_accept && s_end_of_frame)) begin
            col_reg  <= '0;
            row_reg  <= '0;
            wcol_reg <= '0;
            win_reg  <= '0;
            brow_reg <= '0;
            band_reg <= BAND_W'(BANDS - 1);
        end else if (pix_accept) begin
            if (col_reg == COL_W'(IMAGE_WIDTH - 1)) begin
                col_reg  <= '0;
                wcol_reg <= '0;
                win_reg  <= '0;
                if (row_reg == ROW_W'(IMAGE_HEIGHT - 1)) begin
                    row_reg  <= '0;
                    brow_reg <= '0;
                    band_reg <= BAND_W'(BANDS - 1);
                end else begin
                    row_reg <= row_reg + ROW_W'(1);
                    if (row_reg + ROW_W'(1) <= ROW_W'(TOP_SKIP)) begin
                        brow_reg <= '0;
                        band_reg <= BAND_W'(BANDS - 1);
                    end else if (brow_reg == BROW_W'(BAND_ROWS - 1)) begin
                        brow_reg <= '0;
                        if (band_reg != '0) begin
                            band_reg <= band_reg - BAND_W'(1);
                        end
                    end else begin
                        brow_reg <= brow_reg + BROW_W'(1);
                    end
                end
            end else begin
                col_reg <= col_reg + COL_W'(1);
                if (wcol_reg == WCOL_W'(WIN_COLS - 1)) begin
                    wcol_reg <= '0;
                    if (win_reg != WIN_W'(WINDOWS - 1)) begin
                        win_reg <= win_reg + WIN_W'(1);
                    end
                end else begin
                    wcol_reg <= wcol_reg + WCOL_W'(1);
                end
            end
        end
    end

    // count pipeline control and valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            lw_en_reg  <= 1'b0;
            valid_reg  <= '0;
        end else begin
            s1_vld_reg <= pix_accept && count_ok;
            lw_en_reg  <= s1_vld_reg;
            if (walk_done) begin
                valid_reg <= '0;
            end else if (s1_vld_reg) begin
                valid_reg[s1_addr_reg] <= 1'b1;
            end
        end
    end

    // count pipeline payload
    always_ff @(posedge aclk) begin
        s1_addr_reg <= pix_addr;
        rv_bit_reg  <= valid_reg[rd_addr];
        lw_addr_reg <= s1_addr_reg;
        lw_data_reg <= wr_data;
    end

    // band walk sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_PIX;
            rd_pend_reg  <= 1'b0;
            tracking_reg <= 1'b0;
            tracked_reg  <= '0;
            points_reg   <= '0;
            wband_reg    <= '0;
            m_valid      <= 1'b0;
        end else begin
            rd_pend_reg <= (state_reg == ST_SCAN);

            // result valid: raised on emit, dropped once taken
            if (emit_go) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end

            // window compare on the registered read of each scanned window
            if (rd_pend_reg && (walk_cnt > best_cnt_reg) && (walk_cnt < count_limit_reg)) begin
                best_cnt_reg <= walk_cnt;
                best_idx_reg <= rd_idx_reg;
            end

            case (state_reg)
                ST_PIX: begin
                    if (pix_accept && s_end_of_frame) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    wband_reg    <= '0;
                    tracking_reg <= 1'b0;
                    tracked_reg  <= '0;
                    points_reg   <= '0;
                    state_reg    <= ST_SETUP;
                end
                ST_SETUP: begin
                    idx_reg      <= lo_win;
                    hi_reg       <= hi_win;
                    best_cnt_reg <= '0;
                    best_idx_reg <= '0;
                    state_reg    <= ST_SCAN;
                end
                ST_SCAN: begin
                    rd_idx_reg <= idx_reg;
                    if (idx_reg == hi_reg) begin
                        state_reg <= ST_LAST;
                    end else begin
                        idx_reg <= idx_reg + WIN_W'(1);
                    end
                end
                ST_LAST: begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_band          <= OBAND_W'(wband_reg);
                        m_found         <= found;
                        m_window        <= found ? OWIN_W'(best_idx_reg) : '0;
                        m_center_x      <= found ? sx[CX_W-1:0] : '0;
                        m_center_y      <= found ? sy[CY_W-1:0] : '0;
                        m_last          <= walk_done;
                        m_enough_points <= walk_done && (points_next > POINTS_W'(2));
                        points_reg      <= points_next;
                        if (!tracking_reg) begin
                            tracked_reg <= best_idx_reg;
                            if (best_idx_reg != '0) begin
                                tracking_reg <= 1'b1;
                            end
                        end else if (best_idx_reg != '0) begin
                            tracked_reg <= best_idx_reg;
                        end
                        if (walk_done) begin
                            state_reg <= ST_PIX;
                        end else begin
                            wband_reg <= wband_reg + BAND_W'(1);
                            state_reg <= ST_SETUP;
                        end
                    end
                end
                default: state_reg <= ST_PIX;
            endcase
        end
    end

endmodule
`default_nettype wire
